[rtl/dtpy_pkg.sv]
package dtpy_pkg;

  // Datapath width of the CORDIC vector components. Components enter scaled to 2^39 full
  // scale and grow by the CORDIC gain and the quadrant fold, so 44 bits leave headroom.
  localparam int DATA_W = 44;

  // Angle accumulator width: 2^31 stands for pi, and the quadrant fold plus the sum of all
  // micro-rotation angles can pass pi, hence two extra bits.
  localparam int ANG_W = 34;

  // Bits of the positive vector length handed from the first pass to the gain correction.
  localparam int LEN_W = 42;

  // Components are placed so that full scale sits at 2^39.
  localparam int FULL_SCALE_POS = 40;

  localparam logic signed [ANG_W-1:0] HALF_PI_ANG = 34'sd1073741824;

  // Inverse CORDIC gain as a fraction of 2^31.
  localparam int GAIN_W = 31;
  localparam logic [GAIN_W-1:0] INV_GAIN = 31'd1304065748;

  // atan(2^-i) in units where 2^31 stands for pi, rounded to nearest.
  localparam logic [31:0] ATAN_UNITS [0:31] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

endpackage

[rtl/dtpy_cordic.sv]
module dtpy_cordic #(
  parameter int CORDIC_STAGES = 16,
  parameter int SB_W = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic signed [dtpy_pkg::DATA_W-1:0]   in_re,
  input  logic signed [dtpy_pkg::DATA_W-1:0]   in_im,
  input  logic [SB_W-1:0]                      in_sb,
  output logic                                 out_valid,
  output logic signed [dtpy_pkg::DATA_W-1:0]   out_re,
  output logic signed [dtpy_pkg::ANG_W-1:0]    out_ang,
  output logic [SB_W-1:0]                      out_sb
);
  import dtpy_pkg::*;

  logic                      v    [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0]  re   [0:CORDIC_STAGES];
  logic signed [DATA_W-1:0]  im   [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0]   ang  [0:CORDIC_STAGES];
  logic                      zero [0:CORDIC_STAGES];
  logic [SB_W-1:0]           sb   [0:CORDIC_STAGES];

  // Entry stage: fold a vector in the left half-plane into the right one by a quarter turn.
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (in_re == '0) && (in_im == '0);
      sb[0]   <= in_sb;
      if (in_re[DATA_W-1]) begin
        if (!in_im[DATA_W-1]) begin
          re[0]  <= in_im;
          im[0]  <= -in_re;
          ang[0] <= HALF_PI_ANG;
        end else begin
          re[0]  <= -in_im;
          im[0]  <= in_re;
          ang[0] <= -HALF_PI_ANG;
        end
      end else begin
        re[0]  <= in_re;
        im[0]  <= in_im;
        ang[0] <= '0;
      end
    end
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    localparam logic signed [ANG_W-1:0] StepAng = signed'(ANG_W'(ATAN_UNITS[k]));

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero[k+1] <= zero[k];
        sb[k+1]   <= sb[k];
        if (!im[k][DATA_W-1]) begin
          re[k+1]  <= re[k] + (im[k] >>> k);
          im[k+1]  <= im[k] - (re[k] >>> k);
          ang[k+1] <= ang[k] + StepAng;
        end else begin
          re[k+1]  <= re[k] - (im[k] >>> k);
          im[k+1]  <= im[k] + (re[k] >>> k);
          ang[k+1] <= ang[k] - StepAng;
        end
      end
    end
  end

  assign out_valid = v[CORDIC_STAGES];
  assign out_re    = re[CORDIC_STAGES];
  // A null vector has no angle; the rotations above would still have summed one.
  assign out_ang   = zero[CORDIC_STAGES] ? '0 : ang[CORDIC_STAGES];
  assign out_sb    = sb[CORDIC_STAGES];

endmodule

[rtl/dtpy_gain.sv]
module dtpy_gain #(
  parameter int SB_W = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [dtpy_pkg::LEN_W-1:0]          in_len,
  input  logic [SB_W-1:0]                     in_sb,
  output logic                                out_valid,
  output logic signed [dtpy_pkg::DATA_W-1:0]  out_len,
  output logic [SB_W-1:0]                     out_sb
);
  import dtpy_pkg::*;

  localparam int LoW   = 20;
  localparam int HiW   = LEN_W - LoW;
  localparam int PHiW  = HiW + GAIN_W;
  localparam int PLoW  = LoW + GAIN_W;
  localparam int SumW  = PHiW + 1;
  localparam int DropW = GAIN_W - LoW;

  logic             mul_valid;
  logic [PHiW-1:0]  p_hi;
  logic [PLoW-1:0]  p_lo;
  logic [SB_W-1:0]  mul_sb;
  logic [SumW-1:0]  sum;
  logic [SumW-DropW-1:0] res;

  // The length is split into a high and a low part so that each product stays narrow.
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      mul_valid <= in_valid;
      out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi   <= PHiW'(in_len[LEN_W-1:LoW]) * PHiW'(INV_GAIN);
      p_lo   <= PLoW'(in_len[LoW-1:0]) * PLoW'(INV_GAIN);
      mul_sb <= in_sb;
      res    <= sum[SumW-1:DropW];
      out_sb <= mul_sb;
    end
  end

  assign sum     = SumW'(p_hi) + SumW'(p_lo[PLoW-1:LoW]);
  assign out_len = signed'(DATA_W'(res));

endmodule

[rtl/direction_to_pitch_yaw_top.sv]
// Channel  Direction  Payload (lowest bits first)
// s_*      in         dir_x, dir_y, dir_z, COMPONENT_WIDTH bits each, zero-padded to bytes
// m_*      out        pitch_angle, yaw_angle, ANGLE_WIDTH bits each, zero-padded to bytes
//
// One word is taken every cycle while the skid register is empty; the chain of two CORDIC
// passes and the gain correction lies between acceptance and the result register.
// Reset clears only valid bits; the data registers are not reset.
// A skid register behind the result register takes one word while the output is stalled,
// so s_tready is a register and drops only once both hold a word.
module direction_to_pitch_yaw_top #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  parameter int CORDIC_STAGES = 16,
  localparam int IN_TDATA_W = ((3 * COMPONENT_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // dir_x, dir_y, dir_z
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // pitch_angle, yaw_angle
);
  import dtpy_pkg::*;

  localparam int ScaleSh = FULL_SCALE_POS - COMPONENT_WIDTH;
  localparam int Sb2W    = COMPONENT_WIDTH + ANG_W;

  logic                              en;
  logic signed [COMPONENT_WIDTH-1:0] dir_x;
  logic signed [COMPONENT_WIDTH-1:0] dir_y;
  logic signed [COMPONENT_WIDTH-1:0] dir_z;
  logic signed [DATA_W-1:0]          x_scaled;
  logic signed [DATA_W-1:0]          z_scaled;

  logic                              p1_valid;
  logic signed [DATA_W-1:0]          p1_re;
  logic signed [ANG_W-1:0]           p1_ang;
  logic [COMPONENT_WIDTH-1:0]        p1_sb;

  logic                              g_valid;
  logic signed [DATA_W-1:0]          g_len;
  logic [Sb2W-1:0]                   g_sb;
  logic signed [COMPONENT_WIDTH-1:0] g_y;
  logic signed [DATA_W-1:0]          y_neg;

  logic                              p2_valid;
  logic signed [ANG_W-1:0]           p2_ang;
  logic [ANG_W-1:0]                  p2_sb;

  logic signed [ANG_W-1:0]           pitch_sat;
  logic [31:0]                       pitch_sum;
  logic [31:0]                       yaw_sum;
  logic [ANGLE_WIDTH-1:0]            pitch_res;
  logic [ANGLE_WIDTH-1:0]            yaw_res;

  logic                              out_valid;
  logic [ANGLE_WIDTH-1:0]            out_pitch;
  logic [ANGLE_WIDTH-1:0]            out_yaw;
  logic                              skid_valid;
  logic [ANGLE_WIDTH-1:0]            skid_pitch;
  logic [ANGLE_WIDTH-1:0]            skid_yaw;

  assign en       = !skid_valid;
  assign s_tready = en;

  assign dir_x = signed'(s_tdata[COMPONENT_WIDTH-1:0]);
  assign dir_y = signed'(s_tdata[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH]);
  assign dir_z = signed'(s_tdata[3*COMPONENT_WIDTH-1:2*COMPONENT_WIDTH]);

  assign x_scaled = DATA_W'(dir_x) <<< ScaleSh;
  assign z_scaled = DATA_W'(dir_z) <<< ScaleSh;

  // First pass: heading from (z, x) and the gain-scaled horizontal length.
  dtpy_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .SB_W(COMPONENT_WIDTH)
  ) u_yaw_pass (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(s_tvalid && s_tready),
    .in_re(z_scaled),
    .in_im(x_scaled),
    .in_sb(dir_y),
    .out_valid(p1_valid),
    .out_re(p1_re),
    .out_ang(p1_ang),
    .out_sb(p1_sb)
  );

  dtpy_gain #(
    .SB_W(Sb2W)
  ) u_gain (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(p1_valid),
    .in_len(p1_re[LEN_W-1:0]),
    .in_sb({p1_sb, p1_ang}),
    .out_valid(g_valid),
    .out_len(g_len),
    .out_sb(g_sb)
  );

  assign g_y   = signed'(g_sb[Sb2W-1:ANG_W]);
  assign y_neg = -(DATA_W'(g_y) <<< ScaleSh);

  // Second pass: elevation from (horizontal length, -y).
  dtpy_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES),
    .SB_W(ANG_W)
  ) u_pitch_pass (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(g_valid),
    .in_re(g_len),
    .in_im(y_neg),
    .in_sb(g_sb[ANG_W-1:0]),
    .out_valid(p2_valid),
    .out_re(),
    .out_ang(p2_ang),
    .out_sb(p2_sb)
  );

  always_comb begin
    if (p2_ang > HALF_PI_ANG) begin
      pitch_sat = HALF_PI_ANG;
    end else if (p2_ang < -HALF_PI_ANG) begin
      pitch_sat = -HALF_PI_ANG;
    end else begin
      pitch_sat = p2_ang;
    end
  end

  // Below 32 bits, round half up from 2^31 = pi to the output scale; the top bits wrap modulo a full turn.
  if (ANGLE_WIDTH < 32) begin : g_round
    localparam logic [31:0] Half = 32'(1) << (31 - ANGLE_WIDTH);
    assign pitch_sum = pitch_sat[31:0] + Half;
    assign yaw_sum   = p2_sb[31:0] + Half;
  end else begin : g_exact
    assign pitch_sum = pitch_sat[31:0];
    assign yaw_sum   = p2_sb[31:0];
  end

  assign pitch_res = pitch_sum[31 -: ANGLE_WIDTH];
  assign yaw_res   = yaw_sum[31 -: ANGLE_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (en) begin
      if (p2_valid) begin
        if (!out_valid || m_tready) begin
          out_valid <= 1'b1;
          out_pitch <= pitch_res;
          out_yaw   <= yaw_res;
        end else begin
          skid_valid <= 1'b1;
          skid_pitch <= pitch_res;
          skid_yaw   <= yaw_res;
        end
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end else if (m_tready) begin
      skid_valid <= 1'b0;
      out_pitch  <= skid_pitch;
      out_yaw    <= skid_yaw;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_TDATA_W'({out_yaw, out_pitch});

endmodule

[rtl/dtpy_checker.sv]
module dtpy_checker #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16,
  localparam int OUT_TDATA_W = ((2 * ANGLE_WIDTH + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int PitchW = ANGLE_WIDTH + 1;
  localparam logic signed [PitchW-1:0] PitchMax = PitchW'(1) <<< (ANGLE_WIDTH - 2);
  localparam logic signed [PitchW-1:0] PitchMin = -PitchMax;
  localparam int CompW = COMPONENT_WIDTH;

  logic signed [PitchW-1:0] pitch_field;

  assign pitch_field = PitchW'(signed'(m_tdata[ANGLE_WIDTH-1:0]));

  // A stalled result word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled, component width %0d", CompW);

  // The input side can only be held off while a result word waits.
  a_ready_needs_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input held off with no result pending");

  // Input readiness drops only after the output was stalled in the previous cycle.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(s_tready) |-> $past(m_tvalid && !m_tready))
    else $error("input readiness fell without an output stall");

  // Elevation never leaves the closed quarter-turn range.
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_field <= PitchMax) && (pitch_field >= PitchMin))
    else $error("pitch outside plus or minus a quarter turn");

endmodule

bind direction_to_pitch_yaw_top dtpy_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_checker (.*);
